>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked implication, same-cycle consequent.
`define ASSERT_IMPL(lbl, pre, post, msg) \
  `ASSERT_CLK(lbl, (pre) |-> (post), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

>>> rtl/core/bpa_pkg.sv
package bpa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_REUSED   = 3'd0;
  localparam logic [2:0] ST_GROWN    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_FREED    = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  localparam logic [15:0] LIMIT_RESET = 16'd32000;

  // controller -> datapath
  typedef struct packed {
    logic start;     // request transfer taken
    logic scan;      // one step of the first-fit scan
    logic fin_free;  // write back the cleared word
    logic load_out;  // move result into the output register
  } bpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic free_ok;   // free request names an existing page other than 0
    logic scan_end;  // scan resolved this cycle
  } bpa_sts_t;

endpackage

>>> rtl/core/bpa_ctrl.sv
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  output logic              out_valid,
  input  logic              out_stall,
  output bpa_pkg::bpa_cmd_t cmd,
  input  bpa_pkg::bpa_sts_t sts
);
  import bpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FWAIT = 3'd2;
  localparam logic [2:0] S_FWR   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_take;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          if (in_cmd == CMD_ALLOC) begin
            state_next = S_SCAN;
          end else if (sts.free_ok) begin
            state_next = S_FWAIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_FWAIT: state_next = S_FWR;
      S_FWR: begin
        cmd.fin_free = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_take) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_take) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/core/bpa_datapath.sv
module bpa_datapath #(
  parameter int MAX_PAGES = 32768
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::bpa_cmd_t cmd,
  output bpa_pkg::bpa_sts_t sts,
  input  logic              in_cmd,
  input  logic [14:0]       in_page_index,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  output logic [14:0]       result_page,
  output logic [2:0]        status,
  output logic [15:0]       pages_existing
);
  import bpa_pkg::*;

  localparam int WORDS = (MAX_PAGES + 63) / 64;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = AW + 7;
  localparam int XW    = (CW > 16) ? CW : 16;

  logic [63:0]   mem [WORDS];
  logic [63:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_word;
  logic          chk_vld;
  logic          w0_ok;
  logic [CW-1:0] total;
  logic [15:0]   limit;
  logic [5:0]    idx_lo;
  logic [AW+5:0] res_page;
  logic [2:0]    res_status;

  logic [XW-1:0] total_x;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] res_x;
  logic [CW-1:0] tot_m1;
  logic [AW-1:0] last;
  logic [6:0]    tot_lo;
  logic          at_last;
  logic [63:0]   eff;
  logic [63:0]   cand;
  logic [7:0]    byte_nz;
  logic [2:0]    bsel;
  logic [7:0]    bsel_byte;
  logic [2:0]    bbit;
  logic [5:0]    pos;
  logic          hit;
  logic          grow_ok;
  logic [63:0]   grow_bit;
  logic          we;
  logic [AW-1:0] wa;
  logic [63:0]   wd;

  assign total_x = XW'(total);
  assign idx_x   = XW'(in_page_index);
  assign res_x   = XW'(res_page);
  assign tot_m1  = total - 1'b1;
  assign last    = tot_m1[AW+5:6];
  assign tot_lo  = (total[5:0] == 6'd0) ? 7'd64 : {1'b0, total[5:0]};
  assign at_last = (rd_word == last);

  // word 0 is never opened fresh by growth; garbage until its first write
  assign eff = ((rd_word == '0) && !w0_ok) ? 64'd0 : rd_data;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      cand[i] = !eff[i] && !((rd_word == '0) && (i == 0)) && (!at_last || (7'(i) < tot_lo));
    end
  end

  // two-level lowest-set search: byte, then bit
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_nz[j] = |cand[8*j +: 8];
    end
    bsel = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (byte_nz[j]) bsel = 3'(j);
    end
    bsel_byte = cand[8*bsel +: 8];
    bbit = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (bsel_byte[k]) bbit = 3'(k);
    end
  end

  assign pos      = {bsel, bbit};
  assign hit      = |byte_nz;
  assign grow_ok  = (total_x < XW'(limit)) && (total_x < XW'(MAX_PAGES));
  assign grow_bit = 64'd1 << total[5:0];

  assign sts.free_ok  = (idx_x != '0) && (idx_x < total_x);
  assign sts.scan_end = chk_vld && (hit || at_last);

  always_comb begin
    we = 1'b0;
    wa = rd_word;
    wd = eff;
    if (cmd.scan && chk_vld) begin
      if (hit) begin
        we = 1'b1;
        wd = eff | (64'd1 << pos);
      end else if (at_last && grow_ok) begin
        we = 1'b1;
        wa = total[AW+5:6];
        // a page at a word boundary opens a fresh word
        wd = (total[5:0] == 6'd0) ? grow_bit : (eff | grow_bit);
      end
    end
    if (cmd.fin_free) begin
      we = 1'b1;
      wd = eff & ~(64'd1 << idx_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
    rd_word <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= CW'(1);
      limit   <= LIMIT_RESET;
      w0_ok   <= 1'b0;
      chk_vld <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (we && (wa == '0)) w0_ok <= 1'b1;
      if (cmd.start) begin
        chk_vld <= 1'b0;
        if (in_cmd == CMD_ALLOC) begin
          rd_addr <= '0;
        end else begin
          rd_addr <= idx_x[AW+5:6];
        end
      end
      if (cmd.scan) begin
        chk_vld <= 1'b1;
        if (rd_addr != last) rd_addr <= rd_addr + 1'b1;
        if (chk_vld && !hit && at_last && grow_ok) total <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_lo     <= in_page_index[5:0];
      res_page   <= '0;
      res_status <= ST_IGNORED;
    end
    if (cmd.scan && chk_vld) begin
      if (hit) begin
        res_page   <= {rd_word, pos};
        res_status <= ST_REUSED;
      end else if (at_last) begin
        if (grow_ok) begin
          res_page   <= total[AW+5:0];
          res_status <= ST_GROWN;
        end else begin
          res_page   <= '0;
          res_status <= ST_NO_SPACE;
        end
      end
    end
    if (cmd.fin_free) begin
      res_page   <= '0;
      res_status <= ST_FREED;
    end
    if (cmd.load_out) begin
      result_page    <= res_x[14:0];
      status         <= res_status;
      pages_existing <= total_x[15:0];
    end
  end

endmodule

>>> rtl/core/bitmap_page_allocator.sv
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  cmd, page_index
// out       out  out_valid / out_stall result_page, status, pages_existing
// cfg       in   cfg_valid / cfg_ready cfg_data (page_limit)
//
// Allocate: first-fit scan of the used map (64 pages per word, one word
//   read per cycle from the used-map RAM).
// Free: read-modify-write of one map word. Ignored free: no map write.
// Reset: synchronous; count to one, limit to 32000. The map RAM is not swept:
//   words above the count are written fresh when growth reaches them.
// A new request is taken while the previous result waits in the output register.
`include "assert_macros.svh"

module bitmap_page_allocator #(
  parameter int MAX_PAGES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [14:0] page_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] result_page,
  output logic [2:0]  status,
  output logic [15:0] pages_existing,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import bpa_pkg::*;

  bpa_cmd_t dp_cmd;
  bpa_sts_t dp_sts;

  // limit register always takes the transfer; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer: accept, scan, free read-modify-write, result hand-off
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // used-map RAM, page count, limit, first-fit search and output register
  bpa_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .in_cmd         (cmd),
    .in_page_index  (page_index),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .result_page    (result_page),
    .status         (status),
    .pages_existing (pages_existing)
  );

  // one request in flight: input closes right after a transfer
  `ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input open after transfer")

  // a grown page is always the last existing one
  `ASSERT_IMPL(a_grown_is_top, out_valid && (status == ST_GROWN), result_page == (pages_existing[14:0] - 15'd1), "grown page not at top")

  // only a successful allocate carries a page number
  `ASSERT_IMPL(a_page_zero, out_valid && (status == ST_FREED || status == ST_IGNORED || status == ST_NO_SPACE), result_page == 15'd0, "page set without allocation")

endmodule

>>> bench/bitmap_page_allocator_test.sv
module bitmap_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  // Matches the default MAX_PAGES of the block.
  localparam int PAGE_SPAN = 32768;
  // Cycles with no transfer on any channel before the run is abandoned.
  // It leaves a wide margin over a full-map allocate scan.
  localparam int STALL_LIMIT = 4000;
  // Settling time after the last result, sized for the page counts this run reaches.
  localparam int TAIL_CYCLES = 40;

  // One expected result transfer.
  typedef struct {
    logic [14:0] page;
    logic [2:0]  status;
    logic [15:0] existing;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_ALLOC;
  logic [14:0] page_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] result_page;
  logic [2:0]  status;
  logic [15:0] pages_existing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  bitmap_page_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .page_index     (page_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_page    (result_page),
    .status         (status),
    .pages_existing (pages_existing),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the allocator: used bit per page, page count, growth limit.
  // ---------------------------------------------------------------------------
  bit          page_used [PAGE_SPAN];
  int unsigned shadow_pages = 1;        // page 0 exists from reset
  logic [15:0] limit_shadow = LIMIT_RESET;

  alloc_result_t awaited_results[$];    // oldest first

  // When set, neither side idles nor stalls.
  bit no_idle_phase = 1'b0;

  int mismatch_count = 0;
  int results_checked = 0;
  int alloc_count = 0;
  int free_count = 0;
  int limit_writes = 0;
  int unsigned peak_pages = 1;
  int status_tally [0:4] = '{default: 0};

  // Applies one accepted request to the shadow and returns what the block
  // should answer with.
  function automatic alloc_result_t predict_request(input logic c,
                                                    input logic [14:0] idx);
    alloc_result_t r;
    int unsigned p;
    r.page = '0;
    if (c == CMD_ALLOC) begin
      alloc_count++;
      // first fit over existing pages, page 0 never considered
      p = 1;
      while (p < shadow_pages && page_used[p]) p++;
      if (p < shadow_pages) begin
        page_used[p] = 1'b1;
        r.page = 15'(p);
        r.status = ST_REUSED;
      end else if (shadow_pages < limit_shadow && shadow_pages < PAGE_SPAN) begin
        page_used[shadow_pages] = 1'b1;
        r.page = 15'(shadow_pages);
        shadow_pages++;
        r.status = ST_GROWN;
      end else begin
        r.status = ST_NO_SPACE;
      end
    end else begin
      free_count++;
      if (idx == 0 || idx >= shadow_pages) begin
        r.status = ST_IGNORED;
      end else begin
        // clearing an already clear page still counts as freed
        page_used[idx] = 1'b0;
        r.status = ST_FREED;
      end
    end
    r.existing = 16'(shadow_pages);
    if (shadow_pages > peak_pages) peak_pages = shadow_pages;
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Payload is held until the transfer; valid stays high into
  // the next request unless an idle gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input logic c, input logic [14:0] idx);
    in_valid   <= 1'b1;
    cmd        <= c;
    page_index <= idx;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(predict_request(c, idx));
    if (!no_idle_phase && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!no_idle_phase && $urandom_range(0, 99) < 25) @(posedge clk);
    end
  endtask

  // Stop requesting and wait until every awaited result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Limit register write, only ever issued with the block idle.
  task automatic set_page_limit(input logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_shadow = value;
    limit_writes++;
    cfg_valid <= 1'b0;
  endtask

  // A free target that mostly hits a page in use.
  function automatic logic [14:0] pick_used_page();
    int unsigned p;
    int k;
    if (shadow_pages <= 1) return 15'd1;
    for (k = 0; k < 4; k++) begin
      p = $urandom_range(1, shadow_pages - 1);
      if (page_used[p]) return 15'(p);
    end
    return 15'(p);
  endfunction

  // Noise: page 0, the first page past the count, or anywhere at all.
  function automatic logic [14:0] stray_page();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return (shadow_pages < PAGE_SPAN) ? 15'(shadow_pages) : 15'h7fff;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, and a field-by-field check of each transfer
  // against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result page %0d status %0d count %0d",
                                    result_page, status, pages_existing));
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (result_page !== want.page)
            report_mismatch($sformatf("result_page %0d, expected %0d",
                                      result_page, want.page));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (pages_existing !== want.existing)
            report_mismatch($sformatf("pages_existing %0d, expected %0d",
                                      pages_existing, want.existing));
        end
      end
      out_stall <= !no_idle_phase && ($urandom_range(0, 99) < 25);
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("no transfer for %0d cycles, run abandoned", STALL_LIMIT);
    $display("** bitmap_page_allocator: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frees that must be ignored straight after reset: page 0, the first page
  // past the count, and the top index.
  task automatic test_free_ignored();
    issue_request(CMD_FREE, 15'd0);
    issue_request(CMD_FREE, 15'd1);
    issue_request(CMD_FREE, 15'h7fff);
  endtask

  // Growth from an empty map, reuse of holes in first-fit order, a double
  // free, and a free just past the count.
  task automatic test_grow_and_reuse();
    repeat (4) issue_request(CMD_ALLOC, 15'h7fff);
    issue_request(CMD_FREE, 15'd2);
    issue_request(CMD_FREE, 15'd2);
    issue_request(CMD_FREE, 15'd4);
    issue_request(CMD_ALLOC, 15'd0);
    issue_request(CMD_ALLOC, 15'h5555);
    issue_request(CMD_ALLOC, 15'h2aaa);
    issue_request(CMD_FREE, 15'd1);
    issue_request(CMD_FREE, 15'd5);
    issue_request(CMD_FREE, 15'd6);
    issue_request(CMD_ALLOC, 15'd0);
  endtask

  // Limit extremes: 1 and 0 block growth but not reuse; all ones and 32768
  // let growth carry on.
  task automatic test_limit_extremes();
    set_page_limit(16'd1);
    issue_request(CMD_ALLOC, 15'd0);
    issue_request(CMD_ALLOC, 15'd0);
    set_page_limit(16'd0);
    issue_request(CMD_FREE, 15'd3);
    issue_request(CMD_ALLOC, 15'd0);
    issue_request(CMD_ALLOC, 15'd0);
    set_page_limit(16'hffff);
    issue_request(CMD_ALLOC, 15'd0);
    set_page_limit(16'd32768);
    issue_request(CMD_ALLOC, 15'd0);
  endtask

  // One stretch of mixed traffic under one limit setting.
  task automatic run_traffic_phase(input logic [15:0] limit, input int items,
                                   input int alloc_pct, input bit steady);
    int n;
    int roll;
    set_page_limit(limit);
    no_idle_phase = steady;
    for (n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)
        issue_request(CMD_FREE, stray_page());
      else if (roll < 8 + alloc_pct)
        issue_request(CMD_ALLOC, 15'($urandom));
      else
        issue_request(CMD_FREE, pick_used_page());
    end
    drain_results();
    no_idle_phase = 1'b0;
  endtask

  // Alloc and free roughly balanced so the map stays small and scans short.
  // Limits: wide, at or just above the count, below the count, all ones (no idling
  // on either side), anything, and the reset value.
  task automatic test_random_traffic();
    run_traffic_phase(16'd32768, 150, 48, 1'b0);
    run_traffic_phase(16'(shadow_pages + $urandom_range(0, 8)), 130, 60, 1'b0);
    run_traffic_phase(16'($urandom_range(2, 15)), 120, 50, 1'b0);
    run_traffic_phase(16'hffff, 150, 50, 1'b1);
    run_traffic_phase(16'($urandom), 130, 48, 1'b0);
    run_traffic_phase(LIMIT_RESET, 120, 45, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_free_ignored();
    test_grow_and_reuse();
    test_limit_extremes();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d allocate, %0d free), %0d results checked, %0d limit writes, up to %0d pages",
             alloc_count + free_count, alloc_count, free_count, results_checked,
             limit_writes, peak_pages);
    $display("outcomes: %0d reused, %0d grown, %0d no space, %0d freed, %0d ignored",
             status_tally[ST_REUSED], status_tally[ST_GROWN], status_tally[ST_NO_SPACE],
             status_tally[ST_FREED], status_tally[ST_IGNORED]);
    if (mismatch_count == 0) begin
      $display("** bitmap_page_allocator: PASSED **");
    end else begin
      $display("** bitmap_page_allocator: FAILED **");
    end
    $finish;
  end

endmodule
